FILE: design/rdc_pkg.sv
// Shared types, constants and helpers of the radix digit converter.
`default_nettype none

package rdc_pkg;

   localparam int RADIX_W     = 9;
   localparam int DIGIT_W     = 8;
   localparam int COUNT_W     = 6;
   localparam int POS_W       = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 9'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 9'd256;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RADIX       = 2'd0,
      CSR_DIGIT_COUNT = 2'd1,
      CSR_MSD_FIRST   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } buf_ctl_type;

   function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end else begin
         res = r;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: design/rdc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module rdc_div
   import rdc_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [VALUE_BITS-1:0] dividend,
   input  wire logic [RADIX_W-1:0]    divisor,
   output logic                       done,
   output logic [VALUE_BITS-1:0]      quotient,
   output logic [DIGIT_W-1:0]         remainder
);

   localparam int SW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   logic [VALUE_BITS-1:0] q_ff, q_in;
   logic [DIGIT_W-1:0]    r_ff, r_in;
   logic [SW-1:0]         step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RADIX_W-1:0]    partial;
   logic [RADIX_W-1:0]    diff;
   logic                  fits;

   always_comb begin
      partial = {r_ff, q_ff[VALUE_BITS-1]};
      diff    = partial - divisor;
      fits    = (partial >= divisor);
      done_in = busy_ff && (step_ff == '0);
      busy_in = busy_ff;
      step_in = step_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = SW'(VALUE_BITS - 1);
         q_in    = dividend;
         r_in    = '0;
      end else if (busy_ff) begin
         step_in = step_ff - SW'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end
         q_in = {q_ff[VALUE_BITS-2:0], fits};
         r_in = fits ? diff[DIGIT_W-1:0] : partial[DIGIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

`default_nettype wire

FILE: design/rdc_buf.sv
// Digit buffer: one write port, one registered read port.
`default_nettype none

module rdc_buf
   import rdc_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic               clock,
   input  wire buf_ctl_type        ctl,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic [DIGIT_W-1:0] wr_data,
   input  wire logic [AW-1:0]      rd_addr,
   output logic [DIGIT_W-1:0]      rd_data
);

   logic [DIGIT_W-1:0] mem_ff [DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/radix_digit_converter.sv
// Top level of the radix digit converter: registers, sequencer and result port.
//
//   channel  ports                                   direction  word
//   req      req_valid req_ready req_value           in         one signed value
//   rsp      rsp_valid rsp_ready rsp_digit/pos/last  out        one digit
//   csr      csr_valid csr_ready csr_index csr_data  in         one register write
//
// One value at a time. Each digit is computed in the bit-serial divider, and
// each emitted digit passes through a buffer read, then a hold.
// req_ready is high only when no value is in progress; rsp stalls hold the digit.
// Reset is synchronous and clears the sequencer state and the configuration registers.
`default_nettype none

module radix_digit_converter
   import rdc_pkg::*;
#(
   parameter int MAX_DIGITS = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [VALUE_BITS-1:0] req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [DIGIT_W-1:0]                rsp_digit,
   output logic [POS_W-1:0]                  rsp_position,
   output logic                              rsp_last,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_SEND
   } state_type;

   state_type state_ff, state_in;

   logic [RADIX_W-1:0]    radix_ff;
   logic [COUNT_W-1:0]    digit_count_ff;
   logic                  msd_first_ff;

   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         lim_ff, lim_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  auto_ff, auto_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  last_ff, last_in;

   logic                  req_acc;
   logic [VALUE_BITS-1:0] mag_u;
   logic [VALUE_BITS-1:0] mag;
   logic [CW-1:0]         cnt_next;
   logic                  more;
   logic                  div_start;
   logic [VALUE_BITS-1:0] dividend;
   logic                  div_done;
   logic [VALUE_BITS-1:0] quotient;
   logic [DIGIT_W-1:0]    remainder;
   buf_ctl_type           buf_ctl;
   logic [CW-1:0]         rd_sel;
   logic [DIGIT_W-1:0]    rd_data;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= RADIX_RESET;
         digit_count_ff <= '0;
         msd_first_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RADIX: begin
               radix_ff <= csr_data[RADIX_W-1:0];
            end
            CSR_DIGIT_COUNT: begin
               digit_count_ff <= csr_data[COUNT_W-1:0];
            end
            CSR_MSD_FIRST: begin
               msd_first_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      req_acc   = req_valid && (state_ff == ST_IDLE);
      mag_u     = $unsigned(req_value);
      mag       = mag_u[VALUE_BITS-1] ? (~mag_u + VALUE_BITS'(1)) : mag_u;
      cnt_next  = cnt_ff + CW'(1);
      more      = auto_ff ? ((quotient != '0) && (cnt_next < CW'(MAX_DIGITS)))
                          : (cnt_next < lim_ff);
      div_start = req_acc || ((state_ff == ST_DIV) && div_done && more);
      dividend  = req_acc ? mag : quotient;
      rd_sel    = msd_first_ff ? (cnt_ff - CW'(1) - idx_ff) : idx_ff;
      buf_ctl.wr_en = (state_ff == ST_DIV) && div_done;
      buf_ctl.rd_en = (state_ff == ST_READ);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      lim_in       = lim_ff;
      idx_in       = idx_ff;
      auto_in      = auto_ff;
      rsp_valid_in = rsp_valid_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIV;
               cnt_in   = '0;
               idx_in   = '0;
               auto_in  = (digit_count_ff == '0);
               if ({1'b0, digit_count_ff} > 7'(MAX_DIGITS)) begin
                  lim_in = CW'(MAX_DIGITS);
               end else begin
                  lim_in = CW'(digit_count_ff);
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               cnt_in = cnt_next;
               if (!more) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in     = ST_SEND;
            rsp_valid_in = 1'b1;
            pos_in       = POS_W'(idx_ff);
            last_in      = ((idx_ff + CW'(1)) == cnt_ff);
         end
         ST_SEND: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         auto_ff      <= 1'b0;
         lim_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         auto_ff      <= auto_in;
         lim_ff       <= lim_in;
      end
      pos_ff  <= pos_in;
      last_ff <= last_in;
   end

   rdc_div #(
      .VALUE_BITS(VALUE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (eff_radix(radix_ff)),
      .done     (div_done),
      .quotient (quotient),
      .remainder(remainder)
   );

   rdc_buf #(
      .DEPTH(MAX_DIGITS),
      .AW   (AW)
   ) u_buf (
      .clock  (clock),
      .ctl    (buf_ctl),
      .wr_addr(cnt_ff[AW-1:0]),
      .wr_data(remainder),
      .rd_addr(rd_sel[AW-1:0]),
      .rd_data(rd_data)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_digit    = rd_data;
   assign rsp_position = pos_ff;
   assign rsp_last     = last_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("converter ready right after taking a value");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("converter not idle after final digit");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff < cnt_ff))
      else $error("digit index beyond digit count");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide phase");

endmodule

`default_nettype wire

FILE: dv/radix_digit_converter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the radix digit converter: directed and random values.
module radix_digit_converter_test
   import rdc_pkg::*;
();

   localparam int VALUE_W        = 32;
   localparam int MAX_DIG        = 32;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 1200;
   localparam int LONG_HOLD      = 600;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_VALUES   = 40;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic [POS_W-1:0]   position;
      logic               last;
   } digit_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [DIGIT_W-1:0]        rsp_digit;
   logic [POS_W-1:0]          rsp_position;
   logic                      rsp_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = CSR_RADIX;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   logic [RADIX_W-1:0] cfg_radix = RADIX_RESET;
   logic [COUNT_W-1:0] cfg_count = '0;
   logic               cfg_msd = 1'b0;

   digit_word_type pending_digits[$];
   digit_word_type expected_word;
   int          mismatch_count = 0;
   int          stuck_cycles = 0;
   logic        quiet_mode = 1'b0;
   int          hold_requests = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          stall_left = 0;

   radix_digit_converter DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_digit    (rsp_digit),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic void queue_digits(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] quot;
      logic [RADIX_W-1:0] base;
      logic [DIGIT_W-1:0] digits [MAX_DIG];
      int                 len;
      int                 i;
      digit_word_type     word;
      mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
      if (cfg_radix < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (cfg_radix > RADIX_MAX) begin
         base = RADIX_MAX;
      end else begin
         base = cfg_radix;
      end
      if (cfg_count == 0) begin
         len = 0;
         quot = mag;
         do begin
            quot = quot / base;
            len++;
         end while (quot != 0 && len < MAX_DIG);
      end else if (cfg_count > MAX_DIG) begin
         len = MAX_DIG;
      end else begin
         len = int'(cfg_count);
      end
      quot = mag;
      for (i = 0; i < len; i++) begin
         digits[i] = DIGIT_W'(quot % base);
         quot = quot / base;
      end
      for (i = 0; i < len; i++) begin
         word.digit = cfg_msd ? digits[len - 1 - i] : digits[i];
         word.position = POS_W'(i);
         word.last = (i == len - 1);
         pending_digits.push_back(word);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RADIX:       cfg_radix = csr_data;
               CSR_DIGIT_COUNT: cfg_count = csr_data[COUNT_W-1:0];
               CSR_MSD_FIRST:   cfg_msd = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            queue_digits(req_value);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_digits.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("%0t: unexpected word digit %0d position %0d last %0d",
                           $realtime, rsp_digit, rsp_position, rsp_last);
               end
               mismatch_count++;
            end else begin
               expected_word = pending_digits.pop_front();
               if (rsp_digit !== expected_word.digit ||
                   rsp_position !== expected_word.position ||
                   rsp_last !== expected_word.last) begin
                  if (mismatch_count < 10) begin
                     $display({"%0t: mismatch expected digit %0d position %0d last %0d,",
                               " got %0d %0d %0d"},
                              $realtime, expected_word.digit, expected_word.position,
                              expected_word.last, rsp_digit, rsp_position, rsp_last);
                  end
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("radix_digit_converter_test: done, errors");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet_mode && $urandom_range(0, 99) < 20) begin
            stall_left <= pick_gap();
         end
      end
   end

   task automatic send_value(input logic [VALUE_W-1:0] value);
      int gap;
      gap = quiet_mode ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_digits.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] radix_data,
                             input logic [CSR_DATA_W-1:0] count_data,
                             input logic [CSR_DATA_W-1:0] msd_data);
      settle();
      write_csr(CSR_RADIX, radix_data);
      write_csr(CSR_DIGIT_COUNT, count_data);
      write_csr(CSR_MSD_FIRST, msd_data);
   endtask

   task automatic test_reset_defaults();
      send_value(32'd0);
      send_value(32'd12345);
      send_value(32'hffff_ffff);
      send_value(32'h7fff_ffff);
      send_value(32'h8000_0000);
      send_value(32'd1000000000);
   endtask

   task automatic test_radix_extremes();
      set_config(9'd0, 9'd0, 9'd0);
      send_value(32'd5);
      set_config(9'd1, 9'd0, 9'd0);
      send_value(32'h8000_0000);
      set_config(9'd511, 9'd0, 9'd0);
      send_value(32'hdead_beef);
      set_config(9'd256, 9'd0, 9'd0);
      send_value(32'hffff_ffff);
      set_config(9'd257, 9'd0, 9'd0);
      send_value(32'h00ff_00ff);
   endtask

   task automatic test_digit_count();
      set_config(9'd10, 9'd3, 9'd0);
      send_value(32'd123456);
      set_config(9'd10, 9'd12, 9'd0);
      send_value(32'd42);
      set_config(9'd10, 9'd40, 9'd0);
      send_value(32'd7);
      set_config(9'd10, 9'd63, 9'd0);
      send_value(-32'sd99);
      set_config(9'd10, 9'd32, 9'd0);
      send_value(32'h7fff_ffff);
      set_config(9'd10, 9'd0, 9'd0);
      send_value(32'd0);
   endtask

   task automatic test_msd_first();
      set_config(9'd16, 9'd0, 9'd1);
      send_value(32'h1234_abcd);
      send_value(32'd0);
      set_config(9'd16, 9'd5, 9'd1);
      send_value(32'd99);
      set_config(9'd2, 9'd0, 9'd1);
      send_value(32'h8000_0000);
   endtask

   task automatic test_ignored_index();
      set_config(9'd7, 9'd4, 9'd1);
      write_csr(CSR_UNUSED, 9'h1ff);
      send_value(32'd1234);
   endtask

   task automatic test_backpressure();
      int n;
      set_config(9'd10, 9'd0, 9'd0);
      quiet_mode <= 1'b1;
      hold_requests <= hold_requests + 1;
      for (n = 0; n < 5; n++) begin
         send_value($urandom);
      end
      settle();
      quiet_mode <= 1'b0;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int roll;
      logic [VALUE_W-1:0] v;
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
         v = $urandom;
      end else if (roll < 6) begin
         v = $urandom_range(0, 300);
      end else if (roll < 7) begin
         v = -$urandom_range(1, 300);
      end else if (roll < 8) begin
         case ($urandom_range(0, 3))
            0:       v = 32'h0000_0000;
            1:       v = 32'h8000_0000;
            2:       v = 32'h7fff_ffff;
            default: v = 32'hffff_ffff;
         endcase
      end else begin
         v = 32'd1 << $urandom_range(0, 31);
         if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end
      return v;
   endfunction

   task automatic test_random();
      int phase;
      int n;
      int roll;
      logic [CSR_DATA_W-1:0] radix_data;
      logic [COUNT_W-1:0]    count_field;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         roll = $urandom_range(0, 9);
         if (roll == 0) begin
            radix_data = 9'd2;
         end else if (roll == 1) begin
            radix_data = CSR_DATA_W'($urandom_range(0, 1));
         end else if (roll == 2) begin
            radix_data = 9'd256;
         end else if (roll == 3) begin
            radix_data = CSR_DATA_W'($urandom_range(257, 511));
         end else begin
            radix_data = CSR_DATA_W'($urandom_range(3, 255));
         end
         roll = $urandom_range(0, 9);
         if (roll < 4) begin
            count_field = '0;
         end else if (roll < 8) begin
            count_field = COUNT_W'($urandom_range(1, 8));
         end else if (roll < 9) begin
            count_field = COUNT_W'($urandom_range(9, 32));
         end else begin
            count_field = COUNT_W'($urandom_range(33, 63));
         end
         set_config(radix_data, {3'($urandom), count_field}, 9'($urandom));
         quiet_mode <= (phase % 4 == 3);
         for (n = 0; n < PHASE_VALUES; n++) begin
            send_value(pick_value());
         end
         settle();
         quiet_mode <= 1'b0;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_radix_extremes();
      test_digit_count();
      test_msd_first();
      test_ignored_index();
      test_backpressure();
      test_random();
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_digits.size() == 0) begin
         $display("radix_digit_converter_test: done, clean");
      end else begin
         $display("radix_digit_converter_test: done, errors");
      end
      $finish;
   end

endmodule

FILE: files.f
design/rdc_pkg.sv
design/rdc_div.sv
design/rdc_buf.sv
design/radix_digit_converter.sv
dv/radix_digit_converter_test.sv
